[hw/rtl/sgc_pkg.sv]
// ----------------------------------------------------------------------------
// sgc_pkg: shared types and constants for the sorting gate controller
// Field widths, command characters, status codes, register indexes and the
// structs passed between the ring, the gate sequencer and the top level.
// ----------------------------------------------------------------------------
package sgc_pkg;

    localparam int RING_SLOTS_DEF = 16;

    localparam int CMD_W     = 8;
    localparam int STAT_W    = 3;
    localparam int QCNT_W    = 4;
    localparam int TOTAL_W   = 32;
    localparam int CFG_W     = 16;
    localparam int TMR_W     = 16;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [CFG_W-1:0] DELAY_RST   = CFG_W'(400);
    localparam logic [CFG_W-1:0] HOLD_RST    = CFG_W'(400);
    localparam logic [CFG_W-1:0] LOCKOUT_RST = CFG_W'(300);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = CFG_IDX_W'(2);

    // command characters
    localparam logic [CMD_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CMD_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CMD_W-1:0] CH_UR  = 8'h52;  // 'R'
    localparam logic [CMD_W-1:0] CH_LR  = 8'h72;  // 'r'
    localparam logic [CMD_W-1:0] CH_UQ  = 8'h51;  // 'Q'
    localparam logic [CMD_W-1:0] CH_LQ  = 8'h71;  // 'q'
    localparam logic [CMD_W-1:0] CH_ONE = 8'h31;  // '1' good verdict
    localparam logic [CMD_W-1:0] CH_TWO = 8'h32;  // '2' bad verdict

    typedef enum logic [STAT_W-1:0] {
        ST_NONE    = 3'd0,
        ST_GOOD_Q  = 3'd1,
        ST_BAD_Q   = 3'd2,
        ST_FULL    = 3'd3,
        ST_RESET   = 3'd4,
        ST_QUERY   = 3'd5,
        ST_UNKNOWN = 3'd6
    } cmd_status_t;

    // ring status seen by the sequencer and the command decoder
    typedef struct packed {
        logic nonempty;
        logic full;
        logic head_bad;
    } ring_stat_t;

    // post-update view of the sequencer outputs
    typedef struct packed {
        logic [TOTAL_W-1:0] good_total;
        logic [TOTAL_W-1:0] bad_total;
        logic               gate_good;
        logic               gate_bad;
    } gate_view_t;

endpackage

[hw/rtl/sgc_ring.sv]
// ----------------------------------------------------------------------------
// sgc_ring: verdict ring
// One-bit verdict store with head/tail pointers, one slot always left empty.
// The head verdict is read into a register, with write bypass.
// ----------------------------------------------------------------------------
module sgc_ring
    import sgc_pkg::*;
#(
    parameter int RING_SLOTS = RING_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              push_bad,
    input  logic              pop,
    input  logic              clr,
    output ring_stat_t        stat,
    output logic [QCNT_W-1:0] fill_next
);

    localparam int PTR_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int CNT_W = PTR_W + 1;
    localparam int FW    = (CNT_W > QCNT_W) ? CNT_W : QCNT_W;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_SLOTS - 1);

    logic             mem [RING_SLOTS];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             head_bad_reg;
    logic [FW-1:0]    fill_wide;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (clr)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else
        begin
            if (pop)
                head_next = ptr_inc(head_reg);
            if (push)
                tail_next = ptr_inc(tail_reg);
        end
    end

    assign fill_wide = FW'(tail_next)
                     + ((tail_next < head_next) ? FW'(RING_SLOTS) : '0)
                     - FW'(head_next);
    assign fill_next = fill_wide[QCNT_W-1:0];

    assign stat.nonempty = (head_reg != tail_reg);
    assign stat.full     = (ptr_inc(tail_reg) == head_reg);
    assign stat.head_bad = head_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // storage and registered head read
    always_ff @(posedge clk)
    begin
        if (push)
            mem[tail_reg] <= push_bad;
        if (push && (tail_reg == head_next))
            head_bad_reg <= push_bad;
        else
            head_bad_reg <= mem[head_next];
    end

endmodule

[hw/rtl/sgc_gate.sv]
// ----------------------------------------------------------------------------
// sgc_gate: gate sequencer
// Tick timers, sensor edge trigger with lockout, delay/open/hold/close phase
// machine, servo states and diverted-item totals.
// ----------------------------------------------------------------------------
module sgc_gate
    import sgc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic             clr,
    input  logic             good_level,
    input  logic             bad_level,
    input  logic [CFG_W-1:0] delay_ms,
    input  logic [CFG_W-1:0] hold_ms,
    input  logic [CFG_W-1:0] lockout_ms,
    input  ring_stat_t       ring_stat,
    output logic             pop,
    output gate_view_t       view_next
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DELAY,
        PH_OPEN,
        PH_HOLD,
        PH_CLOSE
    } phase_t;

    typedef enum logic [1:0] {
        AV_NONE,
        AV_GOOD,
        AV_BAD
    } verdict_t;

    phase_t             phase_reg, phase_next;
    verdict_t           av_reg, av_next;
    logic [TMR_W-1:0]   pt_reg, pt_next;
    logic [TMR_W-1:0]   glt_reg, glt_next;
    logic [TMR_W-1:0]   blt_reg, blt_next;
    logic               gprev_reg, gprev_next;
    logic               bprev_reg, bprev_next;
    logic [TOTAL_W-1:0] gcnt_reg, gcnt_next;
    logic [TOTAL_W-1:0] bcnt_reg, bcnt_next;
    logic               ggate_reg, ggate_next;
    logic               bgate_reg, bgate_next;
    logic               trig;

    function automatic logic [TMR_W-1:0] sat_inc(input logic [TMR_W-1:0] t);
        sat_inc = (&t) ? t : t + TMR_W'(1);
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        av_next    = av_reg;
        pt_next    = pt_reg;
        glt_next   = glt_reg;
        blt_next   = blt_reg;
        gprev_next = gprev_reg;
        bprev_next = bprev_reg;
        gcnt_next  = gcnt_reg;
        bcnt_next  = bcnt_reg;
        ggate_next = ggate_reg;
        bgate_next = bgate_reg;
        pop        = 1'b0;
        trig       = 1'b0;

        if (clr)
        begin
            phase_next = PH_IDLE;
            av_next    = AV_NONE;
            pt_next    = '0;
            glt_next   = '0;
            blt_next   = '0;
            gprev_next = good_level;
            bprev_next = bad_level;
            gcnt_next  = '0;
            bcnt_next  = '0;
            ggate_next = 1'b0;
            bgate_next = 1'b0;
        end
        else if (tick)
        begin
            pt_next  = sat_inc(pt_reg);
            glt_next = sat_inc(glt_reg);
            blt_next = sat_inc(blt_reg);

            // falling edge on the head verdict's sensor, past its lockout
            if ((phase_reg == PH_IDLE) && ring_stat.nonempty)
            begin
                if (!ring_stat.head_bad)
                begin
                    if (gprev_reg && !good_level && (glt_next > lockout_ms))
                    begin
                        glt_next = '0;
                        trig     = 1'b1;
                    end
                end
                else
                begin
                    if (bprev_reg && !bad_level && (blt_next > lockout_ms))
                    begin
                        blt_next = '0;
                        trig     = 1'b1;
                    end
                end
            end
            if (trig)
            begin
                av_next    = ring_stat.head_bad ? AV_BAD : AV_GOOD;
                pop        = 1'b1;
                pt_next    = '0;
                phase_next = PH_DELAY;
            end
            gprev_next = good_level;
            bprev_next = bad_level;

            case (phase_next)
                PH_DELAY:
                begin
                    if (pt_next > delay_ms)
                        phase_next = PH_OPEN;
                end
                PH_OPEN:
                begin
                    if (av_next == AV_GOOD)
                        ggate_next = 1'b1;
                    else if (av_next == AV_BAD)
                        bgate_next = 1'b1;
                    pt_next    = '0;
                    phase_next = PH_HOLD;
                end
                PH_HOLD:
                begin
                    if (pt_next > hold_ms)
                        phase_next = PH_CLOSE;
                end
                PH_CLOSE:
                begin
                    if (av_next == AV_GOOD)
                    begin
                        ggate_next = 1'b0;
                        gcnt_next  = gcnt_reg + TOTAL_W'(1);
                    end
                    else if (av_next == AV_BAD)
                    begin
                        bgate_next = 1'b0;
                        bcnt_next  = bcnt_reg + TOTAL_W'(1);
                    end
                    av_next    = AV_NONE;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = phase_next;
                end
            endcase
        end
    end

    assign view_next.good_total = gcnt_next;
    assign view_next.bad_total  = bcnt_next;
    assign view_next.gate_good  = ggate_next;
    assign view_next.gate_bad   = bgate_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            av_reg    <= AV_NONE;
            pt_reg    <= '0;
            glt_reg   <= '0;
            blt_reg   <= '0;
            gprev_reg <= 1'b1;
            bprev_reg <= 1'b1;
            gcnt_reg  <= '0;
            bcnt_reg  <= '0;
            ggate_reg <= 1'b0;
            bgate_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            av_reg    <= av_next;
            pt_reg    <= pt_next;
            glt_reg   <= glt_next;
            blt_reg   <= blt_next;
            gprev_reg <= gprev_next;
            bprev_reg <= bprev_next;
            gcnt_reg  <= gcnt_next;
            bcnt_reg  <= bcnt_next;
            ggate_reg <= ggate_next;
            bgate_reg <= bgate_next;
        end
    end

endmodule

[hw/rtl/two_way_sorting_gate_controller.sv]
// ----------------------------------------------------------------------------
// two_way_sorting_gate_controller: top level
// Input register, command decode, config registers and result register
// around the verdict ring and the gate sequencer.
// ----------------------------------------------------------------------------
// Each input transfer is either a millisecond tick carrying both beam sensor
// levels (req_type 0) or a received command byte (req_type 1), and yields
// exactly one result transfer with the command status plus the totals, queue
// fill and servo states after that item. The block takes one item per clock
// when the result side keeps up; each item passes the input register, then
// the result register, and the whole state update for an item sits between
// them, so the next item always sees the state the previous one left. The
// result register decouples the sides: a new item is taken while a finished
// result waits, and the input stalls only while both registers are full.
// Config registers (delay_ms, hold_ms, lockout_ms) are written through the
// cfg channel, always ready, and must only change while no item is in
// flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module two_way_sorting_gate_controller
    import sgc_pkg::*;
#(
    parameter int RING_SLOTS = RING_SLOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // item input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [CMD_W-1:0]     cmd_byte,
    input  logic                 sensor_good_level,
    input  logic                 sensor_bad_level,

    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STAT_W-1:0]    cmd_status,
    output logic [TOTAL_W-1:0]   good_total,
    output logic [TOTAL_W-1:0]   bad_total,
    output logic [QCNT_W-1:0]    queued_items,
    output logic                 gate_good_open,
    output logic                 gate_bad_open,

    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // input stage
    logic               s1_valid_reg;
    logic               s1_type_reg;
    logic [CMD_W-1:0]   s1_cmd_reg;
    logic               s1_good_reg;
    logic               s1_bad_reg;

    // result stage
    logic               out_valid_reg;
    cmd_status_t        status_reg;
    gate_view_t         view_reg;
    logic [QCNT_W-1:0]  fill_reg;

    // config
    logic [CFG_W-1:0]   delay_reg;
    logic [CFG_W-1:0]   hold_reg;
    logic [CFG_W-1:0]   lockout_reg;

    logic               advance;
    logic               s1_fire;
    logic               in_xfer;
    logic               tick;
    logic               clr;
    logic               push;
    logic               push_bad;
    cmd_status_t        status_next;
    ring_stat_t         ring_stat;
    logic               pop;
    gate_view_t         view_next;
    logic [QCNT_W-1:0]  fill_next;

    // handshake: the item in the input stage retires into the result
    // register whenever that register is free or being drained this cycle
    assign advance  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg   <= DELAY_RST;
            hold_reg    <= HOLD_RST;
            lockout_reg <= LOCKOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DELAY:   delay_reg   <= cfg_data;
                CFG_HOLD:    hold_reg    <= cfg_data;
                CFG_LOCKOUT: lockout_reg <= cfg_data;
                default:     ;  // index past the register list: dropped
            endcase
        end
    end

    // command decode; a tick only drives the sequencer
    always_comb
    begin
        status_next = ST_NONE;
        tick        = 1'b0;
        clr         = 1'b0;
        push        = 1'b0;
        push_bad    = 1'b0;
        if (s1_fire)
        begin
            if (!s1_type_reg)
                tick = 1'b1;
            else
            begin
                case (s1_cmd_reg) inside
                    CH_CR, CH_LF:
                        status_next = ST_NONE;
                    CH_UR, CH_LR:
                    begin
                        clr         = 1'b1;
                        status_next = ST_RESET;
                    end
                    CH_UQ, CH_LQ:
                        status_next = ST_QUERY;
                    CH_ONE, CH_TWO:
                    begin
                        push_bad = (s1_cmd_reg == CH_TWO);
                        if (ring_stat.full)
                            status_next = ST_FULL;
                        else
                        begin
                            push        = 1'b1;
                            status_next = push_bad ? ST_BAD_Q : ST_GOOD_Q;
                        end
                    end
                    default:
                        status_next = ST_UNKNOWN;
                endcase
            end
        end
    end

    sgc_ring #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_bad  (push_bad),
        .pop       (pop),
        .clr       (clr),
        .stat      (ring_stat),
        .fill_next (fill_next)
    );

    sgc_gate u_gate (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .clr        (clr),
        .good_level (s1_good_reg),
        .bad_level  (s1_bad_reg),
        .delay_ms   (delay_reg),
        .hold_ms    (hold_reg),
        .lockout_ms (lockout_reg),
        .ring_stat  (ring_stat),
        .pop        (pop),
        .view_next  (view_next)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_type_reg <= req_type;
            s1_cmd_reg  <= cmd_byte;
            s1_good_reg <= sensor_good_level;
            s1_bad_reg  <= sensor_bad_level;
        end
        if (s1_fire)
        begin
            status_reg <= status_next;
            view_reg   <= view_next;
            fill_reg   <= fill_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cmd_status     = status_reg;
    assign good_total     = view_reg.good_total;
    assign bad_total      = view_reg.bad_total;
    assign queued_items   = fill_reg;
    assign gate_good_open = view_reg.gate_good;
    assign gate_bad_open  = view_reg.gate_bad;

endmodule

[hw/rtl/sgc_checker.sv]
// ----------------------------------------------------------------------------
// sgc_checker: port-level checks for the sorting gate controller
// Watches the result channel only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sgc_checker
    import sgc_pkg::*;
#(
    parameter int RING_SLOTS = RING_SLOTS_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STAT_W-1:0]   cmd_status,
    input logic [TOTAL_W-1:0]  good_total,
    input logic [TOTAL_W-1:0]  bad_total,
    input logic [QCNT_W-1:0]   queued_items,
    input logic                gate_good_open,
    input logic                gate_bad_open
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cmd_status)
            && $stable(good_total) && $stable(bad_total)
            && $stable(queued_items))
        else $error("result changed while stalled");

    // only one verdict is ever active
    a_one_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(gate_good_open && gate_bad_open))
        else $error("both gates open");

    // a reset command leaves everything cleared
    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cmd_status == ST_RESET) |-> (good_total == '0)
            && (bad_total == '0) && (queued_items == '0)
            && !gate_good_open && !gate_bad_open)
        else $error("reset command left state behind");

    // a refused verdict means the ring is at capacity
    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cmd_status == ST_FULL)
            |-> (queued_items == QCNT_W'(RING_SLOTS - 1)))
        else $error("queue full reported below capacity");

endmodule

bind two_way_sorting_gate_controller sgc_checker #(
    .RING_SLOTS (RING_SLOTS)
) u_sgc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd_status     (cmd_status),
    .good_total     (good_total),
    .bad_total      (bad_total),
    .queued_items   (queued_items),
    .gate_good_open (gate_good_open),
    .gate_bad_open  (gate_bad_open)
);
